FILE: sv/sm64b32_pkg.sv
package sm64b32_pkg;

	localparam logic [63:0] GOLDEN_STEP = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] MIX_MUL_A   = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [63:0] MIX_MUL_B   = 64'h94d0_49bb_1331_11eb;

	localparam int SHIFT_A = 30;
	localparam int SHIFT_B = 27;
	localparam int SHIFT_C = 31;

	localparam int ID_BITS   = 40;
	localparam int DIGIT_W   = 5;
	localparam int ID_CHARS  = 9;
	localparam int CHAR_W    = 7;

	localparam logic [CHAR_W-1:0] PREFIX_CHAR = 7'd69;

	// Crockford base32 digit to its lower-case ASCII code.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		case (d)
			5'd0:  c = 7'd48;
			5'd1:  c = 7'd49;
			5'd2:  c = 7'd50;
			5'd3:  c = 7'd51;
			5'd4:  c = 7'd52;
			5'd5:  c = 7'd53;
			5'd6:  c = 7'd54;
			5'd7:  c = 7'd55;
			5'd8:  c = 7'd56;
			5'd9:  c = 7'd57;
			5'd10: c = 7'd97;
			5'd11: c = 7'd98;
			5'd12: c = 7'd99;
			5'd13: c = 7'd100;
			5'd14: c = 7'd101;
			5'd15: c = 7'd102;
			5'd16: c = 7'd103;
			5'd17: c = 7'd104;
			5'd18: c = 7'd106;
			5'd19: c = 7'd107;
			5'd20: c = 7'd109;
			5'd21: c = 7'd110;
			5'd22: c = 7'd112;
			5'd23: c = 7'd113;
			5'd24: c = 7'd114;
			5'd25: c = 7'd115;
			5'd26: c = 7'd116;
			5'd27: c = 7'd118;
			5'd28: c = 7'd119;
			5'd29: c = 7'd120;
			5'd30: c = 7'd121;
			5'd31: c = 7'd122;
			default: c = 7'd48;
		endcase
		return c;
	endfunction

endpackage

FILE: sv/splitmix64_base32_id_generator.sv
// An accepted request runs the three 64-bit products of the hash on the shared 32x32
// multiplier and then hands out its nine characters as 9 output beats; output stalls hold
// the block, and no new request is taken until the last character has been accepted.
// A request beat with want_id low is taken while the block is idle and produces no characters.
// Reset (arst_n, asynchronous, active low) clears the request counter, the seed and all
// control state; the block is ready for a request in the first cycle after reset.
module splitmix64_base32_id_generator
	import sm64b32_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [63:0]       cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              want_id,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] id_char,
	output logic              is_final
);

	// The sequencer has three states. In ST_MUL it runs the three 64-bit products of the
	// hash, each one as four phases on a single 32x32 multiplier; in ST_EMIT it hands out
	// the nine characters, one per output beat.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	// Which product of the hash is in the multiplier.
	localparam logic [1:0] SEL_GOLDEN = 2'd0;
	localparam logic [1:0] SEL_MIX_A  = 2'd1;
	localparam logic [1:0] SEL_MIX_B  = 2'd2;

	localparam logic [1:0] PH_LL  = 2'd0;
	localparam logic [1:0] PH_LH  = 2'd1;
	localparam logic [1:0] PH_HL  = 2'd2;
	localparam logic [1:0] PH_FIN = 2'd3;

	localparam logic [3:0] LAST_IDX = 4'(ID_CHARS - 2);

	logic [1:0]         state_q;
	logic [1:0]         phase_q;
	logic [1:0]         sel_q;
	logic [63:0]        seed_q;
	logic [63:0]        count_q;
	logic [63:0]        opnd_q;
	logic [63:0]        prod_q;
	logic [63:0]        acc_q;
	logic [ID_BITS-1:0] bits_q;
	logic [3:0]         char_idx_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  id_char_q;
	logic               is_final_q;

	logic [63:0] mul_const;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [63:0] seed_term;
	logic [63:0] mul_res;
	logic [63:0] seeded;
	logic [63:0] mixed_a;
	logic [63:0] mixed_b;
	logic [63:0] mixed_c;
	logic [63:0] count_nx;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign id_char   = id_char_q;
	assign is_final  = is_final_q;

	always_comb begin
		case (sel_q)
			SEL_GOLDEN: mul_const = GOLDEN_STEP;
			SEL_MIX_A:  mul_const = MIX_MUL_A;
			SEL_MIX_B:  mul_const = MIX_MUL_B;
			default:    mul_const = GOLDEN_STEP;
		endcase
	end

	// The low 64 bits of a 64x64 product are lo*lo plus the two cross products shifted up
	// by 32; the high*high product falls off the top and is never formed.
	assign mul_a = (phase_q == PH_HL) ? opnd_q[63:32] : opnd_q[31:0];
	assign mul_b = (phase_q == PH_LH) ? mul_const[63:32] : mul_const[31:0];
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// The seed is folded into the first accumulation of the golden-ratio product.
	assign seed_term = (sel_q == SEL_GOLDEN) ? seed_q : 64'd0;
	assign mul_res   = acc_q + {prod_q[31:0], 32'd0};
	assign seeded    = mul_res;
	assign mixed_a   = seeded ^ (seeded >> SHIFT_A);
	assign mixed_b   = mul_res ^ (mul_res >> SHIFT_B);
	assign mixed_c   = mul_res ^ (mul_res >> SHIFT_C);
	assign count_nx  = count_q + 64'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 64'd0;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_LL;
			sel_q       <= SEL_GOLDEN;
			count_q     <= 64'd0;
			char_idx_q  <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && want_id) begin
						count_q <= count_nx;
						phase_q <= PH_LL;
						sel_q   <= SEL_GOLDEN;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					phase_q <= phase_q + 2'd1;
					if (phase_q == PH_FIN) begin
						case (sel_q)
							SEL_GOLDEN: sel_q <= SEL_MIX_A;
							SEL_MIX_A:  sel_q <= SEL_MIX_B;
							default: begin
								sel_q       <= SEL_GOLDEN;
								char_idx_q  <= 4'd0;
								out_valid_q <= 1'b1;
								state_q     <= ST_EMIT;
							end
						endcase
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						if (is_final_q) begin
							out_valid_q <= 1'b0;
							state_q     <= ST_IDLE;
						end else begin
							char_idx_q <= char_idx_q + 4'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers carry no reset; every one is loaded before it is used.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				opnd_q <= count_nx;
			end
			ST_MUL: begin
				if (phase_q != PH_FIN) begin
					prod_q <= mul_p;
				end
				case (phase_q)
					PH_LH:   acc_q <= prod_q + seed_term;
					PH_HL:   acc_q <= mul_res;
					default: acc_q <= acc_q;
				endcase
				if (phase_q == PH_FIN) begin
					case (sel_q)
						SEL_GOLDEN: opnd_q <= mixed_a;
						SEL_MIX_A:  opnd_q <= mixed_b;
						default: begin
							bits_q     <= mixed_c[ID_BITS-1:0];
							id_char_q  <= PREFIX_CHAR;
							is_final_q <= 1'b0;
						end
					endcase
				end
			end
			ST_EMIT: begin
				if (out_ready && !is_final_q) begin
					id_char_q  <= digit_char(bits_q[ID_BITS-1 -: DIGIT_W]);
					bits_q     <= {bits_q[ID_BITS-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
					is_final_q <= (char_idx_q == LAST_IDX);
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule

FILE: sv/sm64b32_checker.sv
module sm64b32_checker
	import sm64b32_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              want_id,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CHAR_W-1:0] id_char,
	input logic              is_final
);

	// The block never takes a request while characters are still pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("request channel ready while characters pending");

	// A real request closes the input side on the next cycle.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && want_id) |=> !in_ready)
		else $error("still ready after accepting a request");

	// The nine characters of one identifier follow without a gap.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !is_final) |=> out_valid)
		else $error("gap inside an identifier");

	// After the last character the output side goes quiet.
	a_final_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && is_final) |=> !out_valid)
		else $error("output still valid after the final character");

	// A stalled beat holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(id_char) && $stable(is_final)))
		else $error("stalled output beat changed");

endmodule

bind splitmix64_base32_id_generator sm64b32_checker u_sm64b32_checker (.*);

FILE: bench/splitmix64_base32_id_generator_test.sv
module splitmix64_base32_id_generator_test;
	import sm64b32_pkg::*;

	// The run is cut off here.
	localparam int LIMIT_CYCLES = 200000;
	// Length of the one long receiver hold-off. This is far more than the block can buffer.
	localparam int HOLD_CYCLES = 400;
	// Quiet time before a seed write and at the end. A request beat with want_id low can
	// still be in flight after the last expected character.
	localparam int SETTLE_CYCLES = 30;
	localparam int REPORT_MAX = 10;
	// Chance, in percent, that a beat with want_id low goes in before each real request.
	localparam int NO_ID_PCT = 15;

	// Crockford base32 digit set, packed so that digit d sits in byte 31-d.
	localparam logic [8*32-1:0] DIGIT_SET = "0123456789abcdefghjkmnpqrstvwxyz";

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} id_beat_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [63:0]       cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              want_id = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [CHAR_W-1:0] id_char;
	logic              is_final;

	// This is our own view of the block state: the seed as last written and the
	// number of real requests accepted so far.
	logic [63:0] seed_shadow = '0;
	logic [63:0] id_count = '0;

	bit       request_queue[$];   // want_id values still to be offered
	id_beat_t char_due[$];        // characters the block owes us, oldest first

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit squeeze_on = 1'b0;
	int hold_count = 0;
	int cycle_count = 0;
	int errors = 0;

	wire rx_hold = squeeze_on && (hold_count < HOLD_CYCLES);

	splitmix64_base32_id_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.want_id   (want_id),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.id_char   (id_char),
		.is_final  (is_final)
	);

	always #5 clk = ~clk;

	// The watchdog ends a run that hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= REPORT_MAX)
			$display("%s", msg);
	endtask

	// This is the splitmix64 finalizer applied to seed + golden step * n. The id is the
	// low 40 bits of the result.
	function automatic logic [ID_BITS-1:0] mix_id(input logic [63:0] seed,
			input logic [63:0] n);
		logic [63:0] z;
		z = seed + GOLDEN_STEP * n;
		z = (z ^ (z >> SHIFT_A)) * MIX_MUL_A;
		z = (z ^ (z >> SHIFT_B)) * MIX_MUL_B;
		z = z ^ (z >> SHIFT_C);
		return z[ID_BITS-1:0];
	endfunction

	// Called for every accepted request beat. A beat with want_id high advances the
	// count, and it queues 'E' and then eight digits, most significant first.
	task automatic queue_id_chars(input logic want);
		logic [ID_BITS-1:0] bits;
		logic [DIGIT_W-1:0] d;
		id_beat_t beat;
		if (want) begin
			id_count = id_count + 64'd1;
			bits = mix_id(seed_shadow, id_count);
			beat.ch = PREFIX_CHAR;
			beat.last = 1'b0;
			char_due.push_back(beat);
			for (int k = 0; k < ID_CHARS - 1; k++) begin
				d = bits[ID_BITS-1-DIGIT_W*k -: DIGIT_W];
				beat.ch = DIGIT_SET[8*(31-d) +: CHAR_W];
				beat.last = (k == ID_CHARS - 2);
				char_due.push_back(beat);
			end
		end
	endtask

	// Request driver. A beat that has been offered stays put until it is taken. A new
	// beat is raised independently of in_ready, unless this cycle is picked as idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			want_id <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				queue_id_chars(want_id);
			if (!in_valid || in_ready) begin
				if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					want_id <= request_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// This is the long receiver hold-off. It is counted here so that the request side
	// keeps pushing while the sink is closed.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_count <= 0;
		end else if (rx_hold) begin
			hold_count <= hold_count + 1;
		end
	end

	// Character monitor. It compares every accepted output beat with the oldest
	// character owed, and it randomizes out_ready for the next cycle.
	always @(posedge clk or negedge arst_n) begin : char_monitor
		id_beat_t due;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (char_due.size() == 0) begin
					flag_error($sformatf("unexpected beat: id_char %0d is_final %0b",
						id_char, is_final));
				end else begin
					due = char_due.pop_front();
					if (id_char !== due.ch)
						flag_error($sformatf("id_char: expected %0d, got %0d (id %0d)",
							due.ch, id_char, id_count));
					if (is_final !== due.last)
						flag_error($sformatf("is_final: expected %0b, got %0b (id %0d)",
							due.last, is_final, id_count));
				end
			end
			out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// The seed is only written while the block is idle, so the shadow copy can follow
	// at once.
	task automatic write_seed(input logic [63:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		seed_shadow = value;
	endtask

	// Wait on the falling edge, so that the queues and in_valid have settled.
	task automatic drain;
		while (request_queue.size() != 0 || in_valid || char_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input int n, input int snd_pct, input int rcv_pct,
			input bit squeeze);
		write_seed({$urandom, $urandom});
		send_idle_pct = snd_pct;
		recv_stall_pct = rcv_pct;
		squeeze_on = squeeze;
		for (int i = 0; i < n; i++) begin
			// Now and then a beat with want_id low goes in. It must leave no trace.
			if ($urandom_range(99) < NO_ID_PCT)
				request_queue.push_back(1'b0);
			request_queue.push_back(1'b1);
		end
		drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The first beats run with the seed left at its reset value. A
		// beat with want_id low sits between real requests.
		request_queue.push_back(1'b1);
		request_queue.push_back(1'b0);
		request_queue.push_back(1'b1);
		drain();

		// All-ones seed. Two beats with want_id low arrive back to back while the
		// block is busy.
		write_seed('1);
		request_queue.push_back(1'b1);
		request_queue.push_back(1'b1);
		request_queue.push_back(1'b0);
		request_queue.push_back(1'b0);
		request_queue.push_back(1'b1);
		drain();

		// This seed cancels the next scaled count. The mixer input is zero, so the id is
		// all zero digits.
		write_seed(64'd0 - GOLDEN_STEP * (id_count + 64'd1));
		request_queue.push_back(1'b1);
		request_queue.push_back(1'b1);
		drain();

		write_seed(64'd1);
		request_queue.push_back(1'b1);
		request_queue.push_back(1'b1);
		drain();

		write_seed(64'h8000_0000_0000_0000);
		request_queue.push_back(1'b1);
		drain();

		write_seed(64'd0);
		request_queue.push_back(1'b0);
		request_queue.push_back(1'b1);
		request_queue.push_back(1'b1);
		drain();

		// Random phases, each with a fresh random seed. The phases are: no idling, a
		// sparse sender, a slow sink, both sides idling, and a sink that closes for a
		// long stretch while the sender pushes at full rate.
		random_phase(27, 0, 0, 1'b0);
		random_phase(27, 77, 0, 1'b0);
		random_phase(27, 0, 77, 1'b0);
		random_phase(27, 21, 21, 1'b0);
		random_phase(27, 0, 0, 1'b1);

		if (char_due.size() != 0)
			flag_error($sformatf("%0d characters never arrived", char_due.size()));

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/sm64b32_pkg.sv
sv/splitmix64_base32_id_generator.sv
sv/sm64b32_checker.sv
bench/splitmix64_base32_id_generator_test.sv
